// ===== src/i2cseq_pkg.sv =====
// Shared types, codes and sizes of the I2C master transfer sequencer.
`default_nettype none
package i2cseq_pkg;

   localparam int BufDepth   = 16;
   localparam int BufIdxW    = (BufDepth > 1) ? $clog2(BufDepth) : 1;
   localparam int CountW     = 5;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_EVENT = 2'd1;
   localparam logic [1:0] CMD_WRBUF = 2'd2;

   localparam logic [2:0] ACT_NONE  = 3'd0;
   localparam logic [2:0] ACT_START = 3'd1;
   localparam logic [2:0] ACT_SEND  = 3'd2;
   localparam logic [2:0] ACT_RECV  = 3'd3;
   localparam logic [2:0] ACT_ACK   = 3'd4;
   localparam logic [2:0] ACT_STOP  = 3'd5;

   localparam logic [2:0] ERR_OK        = 3'd0;
   localparam logic [2:0] ERR_BUSY      = 3'd1;
   localparam logic [2:0] ERR_COLLISION = 3'd2;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
   localparam logic [2:0] ERR_ADDR_NACK = 3'd4;
   localparam logic [2:0] ERR_RX_EMPTY  = 3'd5;
   localparam logic [2:0] ERR_DATA_NACK = 3'd6;

   localparam logic [7:0] READ_BIT = 8'h01;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] addr_byte;
      logic [4:0] byte_count;
      logic       bus_busy;
      logic       ack_status;
      logic       rx_full;
      logic [7:0] rx_data;
      logic       write_collision;
      logic       rx_overflow;
      logic [3:0] buf_index;
      logic [7:0] buf_data;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_byte;
      logic       nack_bit;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [3:0] rx_position;
      logic       idle;
      logic [2:0] error;
   } rsp_type;

endpackage
`default_nettype wire

// ===== src/i2cseq_req_if.sv =====
// Request channel carrying one command beat into the sequencer.
`default_nettype none
interface i2cseq_req_if;
   import i2cseq_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/i2cseq_rsp_if.sv =====
// Response channel carrying one result beat out of the sequencer.
`default_nettype none
interface i2cseq_rsp_if;
   import i2cseq_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/i2c_master_transfer_sequencer_core.sv =====
// I2C master transfer sequencer: one command beat in, one result beat out, every
// clock unless responses stall. Each accepted request beat is decoded against the
// current phase and the result is held in an output register, shown in the cycle
// after acceptance; a new request is taken whenever that register is empty or
// being drained. The sixteen-entry transmit buffer lives in flip-flops, read at
// the current byte position and written by buffer-write commands.
`default_nettype none
module i2c_master_transfer_sequencer_core
   import i2cseq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   i2cseq_req_if.sink   req_bus,
   i2cseq_rsp_if.source rsp_bus
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_START = 3'd1;
   localparam logic [2:0] PH_ADDR  = 3'd2;
   localparam logic [2:0] PH_TX    = 3'd3;
   localparam logic [2:0] PH_RX    = 3'd4;
   localparam logic [2:0] PH_ACK   = 3'd5;
   localparam logic [2:0] PH_STOP  = 3'd6;

   logic [2:0]        phase_ff, phase_in;
   logic [7:0]        target_ff, target_in;
   logic [CountW-1:0] pos_ff, pos_in;
   logic [CountW-1:0] end_ff, end_in;
   logic [7:0]        store_ff [BufDepth];
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   req_type           req;
   logic              accept;
   logic [CountW-1:0] count_clamped;
   logic [7:0]        store_byte;
   logic [CountW-1:0] pos_inc;

   assign req            = req_bus.payload;
   assign req_bus.ready  = !reset && (!rsp_valid_ff || rsp_bus.ready);
   assign accept         = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   assign pos_inc = pos_ff + CountW'(1);

   always_comb begin
      if (int'(req.byte_count) > BufDepth) begin
         count_clamped = CountW'(BufDepth);
      end else begin
         count_clamped = req.byte_count;
      end
      if (int'(pos_ff) < BufDepth) begin
         store_byte = store_ff[BufIdxW'(pos_ff)];
      end else begin
         store_byte = 8'h00;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      target_in   = target_ff;
      pos_in      = pos_ff;
      end_in      = end_ff;
      rsp_data_in = '0;
      case (req.cmd)
         CMD_START: begin
            if (req.bus_busy || phase_ff != PH_IDLE) begin
               rsp_data_in.error = ERR_BUSY;
               phase_in          = PH_IDLE;
            end else begin
               target_in          = req.addr_byte;
               pos_in             = '0;
               end_in             = count_clamped;
               rsp_data_in.action = ACT_START;
               phase_in           = PH_START;
            end
         end
         CMD_EVENT: begin
            if (phase_ff == PH_IDLE) begin
               phase_in = PH_IDLE;
            end else if (req.write_collision) begin
               rsp_data_in.error = ERR_COLLISION;
               phase_in          = PH_IDLE;
            end else if (req.rx_overflow) begin
               rsp_data_in.error = ERR_OVERFLOW;
               phase_in          = PH_IDLE;
            end else begin
               case (phase_ff)
                  PH_START: begin
                     rsp_data_in.action  = ACT_SEND;
                     rsp_data_in.tx_byte = target_ff;
                     phase_in            = PH_ADDR;
                  end
                  PH_ADDR: begin
                     if (req.ack_status) begin
                        rsp_data_in.error = ERR_ADDR_NACK;
                        phase_in          = PH_IDLE;
                     end else if ((target_ff & READ_BIT) != 8'h00) begin
                        rsp_data_in.action = ACT_RECV;
                        phase_in           = PH_RX;
                     end else begin
                        rsp_data_in.action  = ACT_SEND;
                        rsp_data_in.tx_byte = store_byte;
                        pos_in              = pos_inc;
                        phase_in            = PH_TX;
                     end
                  end
                  PH_RX: begin
                     if (!req.rx_full) begin
                        rsp_data_in.error = ERR_RX_EMPTY;
                        phase_in          = PH_IDLE;
                     end else begin
                        rsp_data_in.rx_valid    = 1'b1;
                        rsp_data_in.rx_byte     = req.rx_data;
                        rsp_data_in.rx_position = pos_ff[3:0];
                        pos_in                  = pos_inc;
                        rsp_data_in.nack_bit    = (pos_inc >= end_ff);
                        rsp_data_in.action      = ACT_ACK;
                        phase_in                = PH_ACK;
                     end
                  end
                  PH_TX: begin
                     if (req.ack_status) begin
                        rsp_data_in.error = ERR_DATA_NACK;
                        phase_in          = PH_IDLE;
                     end else if (pos_ff >= end_ff) begin
                        rsp_data_in.action = ACT_STOP;
                        phase_in           = PH_STOP;
                     end else begin
                        rsp_data_in.action  = ACT_SEND;
                        rsp_data_in.tx_byte = store_byte;
                        pos_in              = pos_inc;
                     end
                  end
                  PH_ACK: begin
                     if (pos_ff >= end_ff) begin
                        rsp_data_in.action = ACT_STOP;
                        phase_in           = PH_STOP;
                     end else begin
                        rsp_data_in.action = ACT_RECV;
                        phase_in           = PH_RX;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
      rsp_data_in.idle = (phase_in == PH_IDLE);
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         target_ff    <= '0;
         pos_ff       <= '0;
         end_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            target_ff <= target_in;
            pos_ff    <= pos_in;
            end_ff    <= end_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (accept && req.cmd == CMD_WRBUF && int'(req.buf_index) < BufDepth) begin
         store_ff[BufIdxW'(req.buf_index)] <= req.buf_data;
      end
   end

endmodule
`default_nettype wire
